// File: design/qdp_pkg.sv
package qdp_pkg;

  // weight format codes
  localparam logic [1:0] FMT_Q312 = 2'd0;
  localparam logic [1:0] FMT_INT8 = 2'd1;
  localparam logic [1:0] FMT_INT4 = 2'd2;
  localparam logic [1:0] FMT_INT2 = 2'd3;

  // field widths
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned RESULT_W = 32;

  // front to back queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  // offsets of the packed formats
  localparam logic signed [4:0] INT4_OFFSET = 5'sd8;
  localparam logic signed [2:0] INT2_OFFSET = 3'sd2;

  // one decoded element waiting for the back end
  typedef struct packed {
    logic signed [DATA_W-1:0] act;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] scale;
    logic [1:0]               fmt;
    logic                     last;
  } qdp_entry_t;

endpackage

// File: design/quantized_dot_product_top.sv
// Quantized dot product. Each input word carries one Q3.12 activation, the weight word
// holding the matching weight, and the row scale; tlast marks the final element of a row,
// and that element produces one saturated Q19.12 result on the master side, with tuser set
// if the accumulator or the final 32-bit result clipped during the row. The weight format
// register (0 Q3.12, 1 int8, 2 packed int4 minus 8, 3 packed int2 minus 2) is decoded by
// the front end as words arrive, and decoded elements wait in a 4-entry queue, so the slave
// side takes one word per cycle until the queue fills. The back end registers one 16x16
// multiply of each element, then does the saturating accumulate, and takes no new element
// until both are done. For a final element in formats 1 to 3 the result is then scaled,
// where the ACC_WIDTH by 16 bit scale product is built from two partial products, the low
// 32 bits of the sum magnitude times the scale, then the upper bits, one per cycle; in any
// format the result then waits for the master side before the back end takes a new element.
module quantized_dot_product_top #(
  parameter int unsigned ACC_WIDTH = 48,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // activation[15:0], weight_word[31:16], row_scale[47:32]
  input  logic        s_tlast,   // last_element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // dot_result[31:0]
  output logic        m_tuser,   // saturated
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data // weight_format
);
  import qdp_pkg::*;

  qdp_entry_t push_entry;
  qdp_entry_t pop_entry;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_valid;

  // front end: accept and decode
  qdp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .queue_full  (queue_full),
    .push        (push),
    .entry       (push_entry)
  );

  // decoupling queue
  qdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_valid),
    .pop_entry  (pop_entry)
  );

  // back end: accumulate, scale, emit
  qdp_back #(
    .ACC_WIDTH (ACC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (queue_valid),
    .entry       (pop_entry),
    .entry_pop   (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

// File: design/qdp_front.sv
module qdp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [47:0]         s_tdata,
  input  logic                s_tlast,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                queue_full,
  output logic                push,
  output qdp_pkg::qdp_entry_t entry
);
  import qdp_pkg::*;

  logic [1:0]               weight_format;
  logic [1:0]               position;
  logic [7:0]               wbyte;
  logic [3:0]               nib;
  logic [1:0]               crumb;
  logic signed [DATA_W-1:0] weight;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;
  assign wbyte    = s_tdata[23:16];

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_format <= FMT_Q312;
    end else if (cfg_wr_en) begin
      weight_format <= cfg_wr_data;
    end
  end

  // element position within the row, modulo 4
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 2'd0;
    end else if (push) begin
      position <= s_tlast ? 2'd0 : position + 2'd1;
    end
  end

  // weight field select
  always_comb begin
    nib = position[0] ? wbyte[7:4] : wbyte[3:0];
    case (position)
      2'd0:    crumb = wbyte[1:0];
      2'd1:    crumb = wbyte[3:2];
      2'd2:    crumb = wbyte[5:4];
      default: crumb = wbyte[7:6];
    endcase
  end

  // weight decode
  always_comb begin
    unique case (weight_format)
      FMT_Q312: weight = s_tdata[31:16];
      FMT_INT8: weight = DATA_W'(signed'(wbyte));
      FMT_INT4: weight = DATA_W'(signed'({1'b0, nib}) - INT4_OFFSET);
      default:  weight = DATA_W'(signed'({1'b0, crumb}) - INT2_OFFSET);
    endcase
  end

  // queue entry
  always_comb begin
    entry.act    = s_tdata[15:0];
    entry.weight = weight;
    entry.scale  = s_tdata[47:32];
    entry.fmt    = weight_format;
    entry.last   = s_tlast;
  end

endmodule

// File: design/qdp_queue.sv
module qdp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qdp_pkg::qdp_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output qdp_pkg::qdp_entry_t pop_entry
);
  import qdp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qdp_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/qdp_back.sv
module qdp_back #(
  parameter int unsigned ACC_WIDTH = 48,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                entry_valid,
  input  qdp_pkg::qdp_entry_t entry,
  output logic                entry_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tuser
);
  import qdp_pkg::*;

  localparam int unsigned HI_W   = ACC_WIDTH - 32;
  localparam int unsigned FULL_W = ACC_WIDTH + 17;

  localparam logic [2:0] ST_TAKE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_ABS   = 3'd2;
  localparam logic [2:0] ST_MLO   = 3'd3;
  localparam logic [2:0] ST_MHI   = 3'd4;
  localparam logic [2:0] ST_SCALE = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [31:0]       PROD_HALF = 32'd1 << (FRAC_BITS - 1);
  localparam logic [FULL_W-1:0] SCALE_HALF = FULL_W'(1) << (FRAC_BITS - 1);
  localparam logic [31:0]       POS_LIM = 32'h7fff_ffff;
  localparam logic [31:0]       NEG_LIM = 32'h8000_0000;

  logic [2:0]                  state;
  logic signed [31:0]          prod;
  logic signed [DATA_W-1:0]    scale;
  logic [1:0]                  fmt;
  logic                        last;
  logic signed [ACC_WIDTH-1:0] running_sum;
  logic                        clip_seen;
  logic [ACC_WIDTH-1:0]        ms;
  logic [DATA_W-1:0]           mc;
  logic                        neg;
  logic [47:0]                 pp_lo;
  logic [HI_W+15:0]            pp_hi;
  logic [31:0]                 res_data;
  logic                        res_clip;

  logic [31:0]                 pmag;
  logic [31:0]                 prnd;
  logic signed [31:0]          addend;
  logic [ACC_WIDTH:0]          sum_ext;
  logic                        acc_ovf;
  logic                        fit32;
  logic [FULL_W-1:0]           full;
  logic [FULL_W-1:0]           mag;
  logic [31:0]                 lim;
  logic                        mag_clip;
  logic [31:0]                 mag32;
  logic                        out_load;

  assign entry_pop = (state == ST_TAKE) && entry_valid;

  // output register loads when it is free or being drained
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // rounding of Q24 products (format 0 only) and saturating accumulate
  always_comb begin
    pmag    = prod[31] ? 32'(-prod) : 32'(prod);
    prnd    = (pmag + PROD_HALF) >> FRAC_BITS;
    addend  = (fmt == FMT_Q312) ? (prod[31] ? signed'(-prnd) : signed'(prnd)) : prod;
    sum_ext = {running_sum[ACC_WIDTH-1], running_sum}
            + {{(ACC_WIDTH-31){addend[31]}}, addend};
    acc_ovf = sum_ext[ACC_WIDTH] != sum_ext[ACC_WIDTH-1];
  end

  // unscaled result range check
  assign fit32 = (&running_sum[ACC_WIDTH-1:31]) || !(|running_sum[ACC_WIDTH-1:31]);

  // scaled magnitude, rounding and clip
  always_comb begin
    full     = FULL_W'({pp_hi, 32'd0}) + FULL_W'(pp_lo) + SCALE_HALF;
    mag      = full >> FRAC_BITS;
    lim      = neg ? NEG_LIM : POS_LIM;
    mag_clip = mag > FULL_W'(lim);
    mag32    = mag_clip ? lim : mag[31:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_TAKE;
      running_sum <= '0;
      clip_seen   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_TAKE: begin
          if (entry_valid) begin
            prod  <= entry.act * entry.weight;
            scale <= entry.scale;
            fmt   <= entry.fmt;
            last  <= entry.last;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_ovf) begin
            running_sum <= sum_ext[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
            clip_seen   <= 1'b1;
          end else begin
            running_sum <= sum_ext[ACC_WIDTH-1:0];
          end
          state <= last ? ST_ABS : ST_TAKE;
        end
        ST_ABS: begin
          ms  <= running_sum[ACC_WIDTH-1] ? ACC_WIDTH'(-running_sum) : ACC_WIDTH'(running_sum);
          mc  <= scale[DATA_W-1] ? DATA_W'(-scale) : DATA_W'(scale);
          neg <= running_sum[ACC_WIDTH-1] != scale[DATA_W-1];
          if (fmt == FMT_Q312) begin
            if (fit32) begin
              res_data <= running_sum[31:0];
              res_clip <= clip_seen;
            end else begin
              res_data <= running_sum[ACC_WIDTH-1] ? NEG_LIM : POS_LIM;
              res_clip <= 1'b1;
            end
            state <= ST_OUT;
          end else begin
            state <= ST_MLO;
          end
        end
        ST_MLO: begin
          pp_lo <= ms[31:0] * mc;
          state <= ST_MHI;
        end
        ST_MHI: begin
          pp_hi <= ms[ACC_WIDTH-1:32] * mc;
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          res_data <= neg ? 32'(-mag32) : mag32;
          res_clip <= clip_seen || mag_clip;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            m_tdata     <= res_data;
            m_tuser     <= res_clip;
            running_sum <= '0;
            clip_seen   <= 1'b0;
            state       <= ST_TAKE;
          end
        end
        default: begin
          state <= ST_TAKE;
        end
      endcase
    end
  end

endmodule
